>>> sv/sortable_linear_queue_top_defines.svh
// Assertion macros used by the sortable queue datapath.
`ifndef SORTABLE_LINEAR_QUEUE_TOP_DEFINES_SVH
`define SORTABLE_LINEAR_QUEUE_TOP_DEFINES_SVH

// Property that must hold at every clock edge out of reset.
`define SLQ_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Same-cycle implication.
`define SLQ_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SLQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/slq_pkg.sv
// Types, constants and codes shared by the sortable queue modules.
package slq_pkg;

   localparam int unsigned DEPTH    = 128;
   localparam int unsigned IDX_W    = $clog2(DEPTH);
   localparam int unsigned CNT_W    = $clog2(DEPTH + 1);
   localparam int unsigned WORD_W   = 32;
   localparam int unsigned FUNC_W   = 2;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned POS_W    = 7;

   typedef enum logic [FUNC_W-1:0] {
      FN_ENQ,
      FN_DEQ,
      FN_SORT,
      FN_SEARCH
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK,
      ST_FULL,
      ST_EMPTY,
      ST_NOT_FOUND,
      ST_NOT_SORTED
   } status_type;

   typedef enum logic [3:0] {
      CS_IDLE,
      CS_DEQ,
      CS_SORT_INIT,
      CS_SORT_FIRST,
      CS_SORT_STEP,
      CS_SORT_FLUSH,
      CS_SRCH_INIT,
      CS_SRCH_CHK0,
      CS_SRCH_CHK1,
      CS_SRCH_MID,
      CS_SRCH_CMP,
      CS_FINISH
   } ctl_state_type;

   typedef enum logic [3:0] {
      DP_HOLD,
      DP_ACCEPT,
      DP_DEQ,
      DP_SORT_INIT,
      DP_SORT_FIRST,
      DP_SORT_STEP,
      DP_SORT_FLUSH,
      DP_SRCH_INIT,
      DP_SRCH_CHK0,
      DP_SRCH_CHK1,
      DP_SRCH_MID,
      DP_SRCH_CMP
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic sort_short;
      logic sort_last_step;
      logic sort_last_pass;
      logic srch_empty;
      logic srch_two;
      logic not_sorted;
      logic range_empty;
      logic match;
   } dp_stat_type;

endpackage

>>> sv/slq_ifs.sv
// Request and response channel interfaces of the sortable queue.
interface slq_req_if;
   logic                                valid;
   logic                                ready;
   logic [slq_pkg::FUNC_W-1:0]          func;
   logic signed [slq_pkg::WORD_W-1:0]   operand_value;

   modport source (output valid, func, operand_value, input ready);
   modport sink (input valid, func, operand_value, output ready);
endinterface

interface slq_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [slq_pkg::STATUS_W-1:0]        status;
   logic signed [slq_pkg::WORD_W-1:0]   result_value;
   logic [slq_pkg::POS_W-1:0]           position;

   modport source (output valid, status, result_value, position, input ready);
   modport sink (input valid, status, result_value, position, output ready);
endinterface

>>> sv/slq_ctrl.sv
// Sequencing state machine of the sortable queue.
module slq_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [slq_pkg::FUNC_W-1:0] req_func,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output slq_pkg::dp_cmd_type        cmd,
   input  slq_pkg::dp_stat_type       stat
);

   slq_pkg::ctl_state_type state_ff, state_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   out_free;

   // output register may be refilled when empty or being taken this cycle
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= slq_pkg::CS_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         slq_pkg::CS_IDLE: begin
            if (req_valid) begin
               case (slq_pkg::func_type'(req_func))
                  slq_pkg::FN_ENQ:  state_in = slq_pkg::CS_FINISH;
                  slq_pkg::FN_DEQ:  state_in = slq_pkg::CS_DEQ;
                  slq_pkg::FN_SORT: state_in = slq_pkg::CS_SORT_INIT;
                  default:          state_in = slq_pkg::CS_SRCH_INIT;
               endcase
            end
         end
         slq_pkg::CS_DEQ:        state_in = slq_pkg::CS_FINISH;
         slq_pkg::CS_SORT_INIT:  state_in = stat.sort_short ? slq_pkg::CS_FINISH
                                                             : slq_pkg::CS_SORT_FIRST;
         slq_pkg::CS_SORT_FIRST: state_in = slq_pkg::CS_SORT_STEP;
         slq_pkg::CS_SORT_STEP:  state_in = stat.sort_last_step ? slq_pkg::CS_SORT_FLUSH
                                                                 : slq_pkg::CS_SORT_STEP;
         slq_pkg::CS_SORT_FLUSH: state_in = stat.sort_last_pass ? slq_pkg::CS_FINISH
                                                                 : slq_pkg::CS_SORT_FIRST;
         slq_pkg::CS_SRCH_INIT: begin
            if (stat.srch_empty) begin
               state_in = slq_pkg::CS_FINISH;
            end else if (stat.srch_two) begin
               state_in = slq_pkg::CS_SRCH_CHK0;
            end else begin
               state_in = slq_pkg::CS_SRCH_MID;
            end
         end
         slq_pkg::CS_SRCH_CHK0:  state_in = slq_pkg::CS_SRCH_CHK1;
         slq_pkg::CS_SRCH_CHK1:  state_in = stat.not_sorted ? slq_pkg::CS_FINISH
                                                             : slq_pkg::CS_SRCH_MID;
         slq_pkg::CS_SRCH_MID:   state_in = stat.range_empty ? slq_pkg::CS_FINISH
                                                              : slq_pkg::CS_SRCH_CMP;
         slq_pkg::CS_SRCH_CMP:   state_in = stat.match ? slq_pkg::CS_FINISH
                                                        : slq_pkg::CS_SRCH_MID;
         slq_pkg::CS_FINISH:     state_in = out_free ? slq_pkg::CS_IDLE : slq_pkg::CS_FINISH;
         default:                state_in = slq_pkg::CS_IDLE;
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      cmd.op       = slq_pkg::DP_HOLD;
      cmd.load_rsp = 1'b0;
      case (state_ff)
         slq_pkg::CS_IDLE: begin
            req_ready = 1'b1;
            cmd.op    = req_valid ? slq_pkg::DP_ACCEPT : slq_pkg::DP_HOLD;
         end
         slq_pkg::CS_DEQ:        cmd.op = slq_pkg::DP_DEQ;
         slq_pkg::CS_SORT_INIT:  cmd.op = slq_pkg::DP_SORT_INIT;
         slq_pkg::CS_SORT_FIRST: cmd.op = slq_pkg::DP_SORT_FIRST;
         slq_pkg::CS_SORT_STEP:  cmd.op = slq_pkg::DP_SORT_STEP;
         slq_pkg::CS_SORT_FLUSH: cmd.op = slq_pkg::DP_SORT_FLUSH;
         slq_pkg::CS_SRCH_INIT:  cmd.op = slq_pkg::DP_SRCH_INIT;
         slq_pkg::CS_SRCH_CHK0:  cmd.op = slq_pkg::DP_SRCH_CHK0;
         slq_pkg::CS_SRCH_CHK1:  cmd.op = slq_pkg::DP_SRCH_CHK1;
         slq_pkg::CS_SRCH_MID:   cmd.op = slq_pkg::DP_SRCH_MID;
         slq_pkg::CS_SRCH_CMP:   cmd.op = slq_pkg::DP_SRCH_CMP;
         slq_pkg::CS_FINISH:     cmd.load_rsp = out_free;
         default:                cmd.op = slq_pkg::DP_HOLD;
      endcase
      // hold the beat until taken, refill on load
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

endmodule

>>> sv/slq_dp.sv
// Datapath of the sortable queue: entry store, indexes, sort and search registers.
`include "sortable_linear_queue_top_defines.svh"

module slq_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  slq_pkg::dp_cmd_type               cmd,
   output slq_pkg::dp_stat_type              stat,
   input  logic [slq_pkg::FUNC_W-1:0]        req_func,
   input  logic signed [slq_pkg::WORD_W-1:0] req_operand_value,
   output logic [slq_pkg::STATUS_W-1:0]      rsp_status,
   output logic signed [slq_pkg::WORD_W-1:0] rsp_result_value,
   output logic [slq_pkg::POS_W-1:0]         rsp_position
);

   localparam int unsigned IDX_W  = slq_pkg::IDX_W;
   localparam int unsigned CNT_W  = slq_pkg::CNT_W;
   localparam int unsigned WORD_W = slq_pkg::WORD_W;
   localparam int unsigned POS_W  = slq_pkg::POS_W;

   logic [WORD_W-1:0] entry_store [slq_pkg::DEPTH];

   logic [IDX_W-1:0]    head_ff, head_in;
   logic [CNT_W-1:0]    tail_ff, tail_in;
   logic [IDX_W-1:0]    j_ff, j_in;
   logic [IDX_W-1:0]    end_ff, end_in;
   logic [IDX_W-1:0]    mid_ff, mid_in;
   logic [CNT_W-1:0]    lo_ff, lo_in;
   logic [CNT_W-1:0]    ub_ff, ub_in;
   logic [WORD_W-1:0]   carry_ff, carry_in;
   logic [WORD_W-1:0]   key_ff, key_in;
   logic [WORD_W-1:0]   rd_data_ff;

   slq_pkg::status_type pend_status_ff, pend_status_in;
   logic [WORD_W-1:0]   pend_result_ff, pend_result_in;
   logic [POS_W-1:0]    pend_pos_ff, pend_pos_in;

   logic [slq_pkg::STATUS_W-1:0] out_status_ff;
   logic [WORD_W-1:0]            out_result_ff;
   logic [POS_W-1:0]             out_pos_ff;

   logic [IDX_W-1:0]  rd_addr;
   logic [IDX_W-1:0]  wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic              wr_en;

   logic [CNT_W-1:0]  head_ext;
   logic [CNT_W-1:0]  live;
   logic [CNT_W-1:0]  span;
   logic [CNT_W-1:0]  mid_calc;
   logic              swap;
   logic              empty;

   assign head_ext = CNT_W'(head_ff);
   assign live     = tail_ff - head_ext;
   assign span     = ub_ff - lo_ff - CNT_W'(1);
   assign mid_calc = lo_ff + (span >> 1);
   assign swap     = $signed(carry_ff) > $signed(rd_data_ff);
   assign empty    = (tail_ff == '0) || (head_ext >= tail_ff);

   assign stat.sort_short     = live < CNT_W'(2);
   assign stat.sort_last_step = (j_ff + IDX_W'(1)) == end_ff;
   assign stat.sort_last_pass = end_ff == (head_ff + IDX_W'(1));
   assign stat.srch_empty     = empty;
   assign stat.srch_two       = live >= CNT_W'(2);
   assign stat.not_sorted     = swap;
   assign stat.range_empty    = lo_ff >= ub_ff;
   assign stat.match          = rd_data_ff == key_ff;

   assign rsp_status       = out_status_ff;
   assign rsp_result_value = out_result_ff;
   assign rsp_position     = out_pos_ff;

   always_comb begin
      head_in        = head_ff;
      tail_in        = tail_ff;
      j_in           = j_ff;
      end_in         = end_ff;
      mid_in         = mid_ff;
      lo_in          = lo_ff;
      ub_in          = ub_ff;
      carry_in       = carry_ff;
      key_in         = key_ff;
      pend_status_in = pend_status_ff;
      pend_result_in = pend_result_ff;
      pend_pos_in    = pend_pos_ff;
      rd_addr        = head_ff;
      wr_addr        = IDX_W'(tail_ff);
      wr_data        = req_operand_value;
      wr_en          = 1'b0;
      case (cmd.op)
         slq_pkg::DP_HOLD: begin
            rd_addr = head_ff;
         end
         slq_pkg::DP_ACCEPT: begin
            key_in         = req_operand_value;
            pend_status_in = slq_pkg::ST_OK;
            pend_result_in = '0;
            pend_pos_in    = '0;
            if (slq_pkg::func_type'(req_func) == slq_pkg::FN_ENQ) begin
               // no wrap: once the last slot is used the queue stays full
               if (tail_ff == CNT_W'(slq_pkg::DEPTH)) begin
                  pend_status_in = slq_pkg::ST_FULL;
               end else begin
                  wr_en   = 1'b1;
                  tail_in = tail_ff + CNT_W'(1);
               end
            end
         end
         slq_pkg::DP_DEQ: begin
            if (empty) begin
               pend_status_in = slq_pkg::ST_EMPTY;
            end else begin
               pend_result_in = rd_data_ff;
               // rewind both indexes when the last live entry leaves
               if ((head_ext + CNT_W'(1)) >= tail_ff) begin
                  head_in = '0;
                  tail_in = '0;
               end else begin
                  head_in = head_ff + IDX_W'(1);
               end
            end
         end
         slq_pkg::DP_SORT_INIT: begin
            end_in  = IDX_W'(tail_ff - CNT_W'(1));
            j_in    = head_ff;
            rd_addr = head_ff;
         end
         slq_pkg::DP_SORT_FIRST: begin
            carry_in = rd_data_ff;
            rd_addr  = j_ff + IDX_W'(1);
         end
         slq_pkg::DP_SORT_STEP: begin
            // carry holds the largest seen so far in this pass; drop the smaller behind it
            wr_en    = 1'b1;
            wr_addr  = j_ff;
            wr_data  = swap ? rd_data_ff : carry_ff;
            carry_in = swap ? carry_ff : rd_data_ff;
            j_in     = j_ff + IDX_W'(1);
            rd_addr  = j_ff + IDX_W'(2);
         end
         slq_pkg::DP_SORT_FLUSH: begin
            wr_en   = 1'b1;
            wr_addr = end_ff;
            wr_data = carry_ff;
            end_in  = end_ff - IDX_W'(1);
            j_in    = head_ff;
            rd_addr = head_ff;
         end
         slq_pkg::DP_SRCH_INIT: begin
            lo_in   = head_ext;
            ub_in   = tail_ff;
            rd_addr = head_ff;
            if (empty) begin
               pend_status_in = slq_pkg::ST_NOT_FOUND;
            end
         end
         slq_pkg::DP_SRCH_CHK0: begin
            carry_in = rd_data_ff;
            rd_addr  = head_ff + IDX_W'(1);
         end
         slq_pkg::DP_SRCH_CHK1: begin
            if (swap) begin
               pend_status_in = slq_pkg::ST_NOT_SORTED;
            end
         end
         slq_pkg::DP_SRCH_MID: begin
            mid_in  = IDX_W'(mid_calc);
            rd_addr = IDX_W'(mid_calc);
            if (lo_ff >= ub_ff) begin
               pend_status_in = slq_pkg::ST_NOT_FOUND;
            end
         end
         slq_pkg::DP_SRCH_CMP: begin
            if (rd_data_ff == key_ff) begin
               pend_status_in = slq_pkg::ST_OK;
               pend_pos_in    = POS_W'(mid_ff);
            end else if ($signed(key_ff) < $signed(rd_data_ff)) begin
               ub_in = CNT_W'(mid_ff);
            end else begin
               lo_in = CNT_W'(mid_ff) + CNT_W'(1);
            end
         end
         default: begin
            rd_addr = head_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      j_ff           <= j_in;
      end_ff         <= end_in;
      mid_ff         <= mid_in;
      lo_ff          <= lo_in;
      ub_ff          <= ub_in;
      carry_ff       <= carry_in;
      key_ff         <= key_in;
      pend_status_ff <= pend_status_in;
      pend_result_ff <= pend_result_in;
      pend_pos_ff    <= pend_pos_in;
      if (cmd.load_rsp) begin
         out_status_ff <= pend_status_ff;
         out_result_ff <= pend_result_ff;
         out_pos_ff    <= pend_pos_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_store[wr_addr] <= wr_data;
      end
      rd_data_ff <= entry_store[rd_addr];
   end

   `SLQ_ASSERT_ALWAYS(a_tail_bound, tail_ff <= CNT_W'(slq_pkg::DEPTH), "tail beyond store depth")
   `SLQ_ASSERT_IMPLY(a_empty_rewound, tail_ff == '0, head_ff == '0, "empty queue not rewound")
   `SLQ_ASSERT_IMPLY(a_head_below_tail, tail_ff != '0, head_ext < tail_ff, "head not below tail")
   `SLQ_ASSERT_IMPLY(a_probe_in_range, cmd.op == slq_pkg::DP_SRCH_CMP, lo_ff < ub_ff, "probe outside range")
   `SLQ_ASSERT_NEXT(a_enq_advances, (cmd.op == slq_pkg::DP_ACCEPT) && (req_func == slq_pkg::FN_ENQ) && (tail_ff != CNT_W'(slq_pkg::DEPTH)), tail_ff == ($past(tail_ff) + CNT_W'(1)), "enqueue did not advance tail")

endmodule

>>> sv/sortable_linear_queue_top.sv
// Top level of the sortable linear queue.
// A linear, non-wrapping queue of up to 128 signed 32-bit entries held in one
// single-port-read, single-port-write memory. One request is worked at a time;
// the next is taken as soon as the previous result sits in the output register.
// With n live entries, sort returns at once when n < 2 and otherwise runs bubble
// passes that carry the larger value forward; search returns at once on an empty
// queue and otherwise checks the order of the first pair when n >= 2, then makes
// halving probes, with a closing empty-range check when the key is absent. The
// single memory read port reads one entry per cycle through a registered read.
module sortable_linear_queue_top (
   input  logic       clock,
   input  logic       reset,
   slq_req_if.sink    req_ch,
   slq_rsp_if.source  rsp_ch
);

   slq_pkg::dp_cmd_type  cmd;
   slq_pkg::dp_stat_type stat;

   slq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .req_func  (req_ch.func),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   slq_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_func          (req_ch.func),
      .req_operand_value (req_ch.operand_value),
      .rsp_status        (rsp_ch.status),
      .rsp_result_value  (rsp_ch.result_value),
      .rsp_position      (rsp_ch.position)
   );

endmodule

>>> dv/tb_sortable_linear_queue_top.sv
// Self-checking testbench for the sortable linear queue: random and directed ops, scoreboarded.
module tb_sortable_linear_queue_top;

   typedef logic signed [slq_pkg::WORD_W-1:0] word_type;

   typedef struct {
      slq_pkg::status_type          status;
      word_type                     value;
      logic [slq_pkg::POS_W-1:0]    position;
   } queue_rsp_type;

   localparam word_type    WORD_MAX    = 32'sh7FFF_FFFF;
   localparam word_type    WORD_MIN    = 32'sh8000_0000;
   localparam int unsigned CYCLE_LIMIT = 1_000_000;

   // Mirror of the queue contents; works out the response of every accepted request.
   class queue_result_board;
      word_type      entries [slq_pkg::DEPTH];
      int unsigned   head_idx;
      int unsigned   tail_idx;
      queue_rsp_type awaited_rsps [$];
      int unsigned   failures;

      function new();
         head_idx = 0;
         tail_idx = 0;
         failures = 0;
         foreach (entries[i]) entries[i] = '0;
      endfunction

      function int unsigned pending_count();
         return awaited_rsps.size();
      endfunction

      function int unsigned live_count();
         return (tail_idx > head_idx) ? tail_idx - head_idx : 0;
      endfunction

      function int unsigned used_slots();
         return tail_idx;
      endfunction

      function word_type live_entry(int unsigned i);
         return entries[head_idx + i];
      endfunction

      function void sort_live();
         int unsigned n;
         word_type    t;
         n = live_count();
         if (n < 2) return;
         for (int unsigned pass = 0; pass + 1 < n; pass++) begin
            for (int unsigned j = head_idx; j + 1 < tail_idx - pass; j++) begin
               if (entries[j] > entries[j + 1]) begin
                  t = entries[j];
                  entries[j] = entries[j + 1];
                  entries[j + 1] = t;
               end
            end
         end
      endfunction

      function slq_pkg::status_type search_live(word_type key, output int unsigned found_at);
         int lo;
         int up;
         int mid;
         found_at = 0;
         if (tail_idx == 0 || head_idx >= tail_idx) return slq_pkg::ST_NOT_FOUND;
         // only the first pair is checked for order
         if (tail_idx - head_idx >= 2 && entries[head_idx] > entries[head_idx + 1])
            return slq_pkg::ST_NOT_SORTED;
         lo = head_idx;
         up = tail_idx - 1;
         while (lo <= up) begin
            mid = lo + (up - lo) / 2;
            if (entries[mid] == key) begin
               found_at = mid;
               return slq_pkg::ST_OK;
            end
            if (key < entries[mid]) up = mid - 1;
            else lo = mid + 1;
         end
         return slq_pkg::ST_NOT_FOUND;
      endfunction

      function void note_request(slq_pkg::func_type fn, word_type operand);
         queue_rsp_type e;
         int unsigned   found_at;
         e.status   = slq_pkg::ST_OK;
         e.value    = '0;
         e.position = '0;
         case (fn)
            slq_pkg::FN_ENQ: begin
               if (tail_idx >= slq_pkg::DEPTH) begin
                  e.status = slq_pkg::ST_FULL;
               end else begin
                  entries[tail_idx] = operand;
                  tail_idx++;
               end
            end
            slq_pkg::FN_DEQ: begin
               if (tail_idx == 0 || head_idx >= tail_idx) begin
                  e.status = slq_pkg::ST_EMPTY;
               end else begin
                  e.value = entries[head_idx];
                  // rewind both indexes once the last entry leaves
                  if (head_idx + 1 >= tail_idx) begin
                     head_idx = 0;
                     tail_idx = 0;
                  end else begin
                     head_idx++;
                  end
               end
            end
            slq_pkg::FN_SORT: sort_live();
            default: begin
               e.status = search_live(operand, found_at);
               if (e.status == slq_pkg::ST_OK) e.position = found_at[slq_pkg::POS_W-1:0];
            end
         endcase
         awaited_rsps.push_back(e);
      endfunction

      function void check_response(logic [slq_pkg::STATUS_W-1:0] st, word_type val,
                                   logic [slq_pkg::POS_W-1:0] pos);
         queue_rsp_type e;
         if (awaited_rsps.size() == 0) begin
            $display("%0t: response beat with nothing pending: status %0d value %0d pos %0d",
                     $time, st, val, pos);
            failures++;
            return;
         end
         e = awaited_rsps.pop_front();
         if (st !== e.status || val !== e.value || pos !== e.position) begin
            $display("%0t: mismatch: expected status %0d value %0d pos %0d,",
                     $time, e.status, e.value, e.position);
            $display("%0t:           got status %0d value %0d pos %0d",
                     $time, st, val, pos);
            failures++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   slq_req_if req_bus ();
   slq_rsp_if rsp_bus ();

   sortable_linear_queue_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   queue_result_board board;
   int unsigned       items_sent;
   int unsigned       snd_idle_pct;
   int unsigned       rcv_idle_pct;
   int unsigned       hold_off_cycles;
   int unsigned       cycle_count;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Receiver: long hold-off when asked, else random stalls.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_off_cycles--;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rcv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         board.check_response(rsp_bus.status, rsp_bus.result_value, rsp_bus.position);
   end

   task automatic send(slq_pkg::func_type fn, word_type operand);
      @(negedge clock);
      while ($urandom_range(99) < snd_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.func          <= fn;
      req_bus.operand_value <= operand;
      // hold the beat until the block takes it
      do @(posedge clock); while (!req_bus.ready);
      board.note_request(fn, operand);
      items_sent++;
   endtask

   function automatic word_type pick_value(int unsigned style);
      int narrow;
      case (style)
         0: return word_type'($urandom);
         1: begin
            narrow = $urandom_range(15);
            return word_type'(narrow - 8);
         end
         default: begin
            case ($urandom_range(5))
               0: return WORD_MIN;
               1: return WORD_MAX;
               2: return '0;
               3: return -1;
               4: return WORD_MIN + word_type'($urandom_range(3));
               default: return word_type'($urandom);
            endcase
         end
      endcase
   endfunction

   // Mostly keys that are present, so that searches run to a hit.
   function automatic word_type pick_key(int unsigned style);
      int unsigned n;
      n = board.live_count();
      if (n > 0 && $urandom_range(9) < 7)
         return board.live_entry($urandom_range(n - 1));
      return pick_value(style);
   endfunction

   task automatic drain_queue();
      while (board.live_count() > 0) send(slq_pkg::FN_DEQ, word_type'($urandom));
   endtask

   task automatic wait_for_idle();
      // drop the request line so that the last beat is not taken again
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (board.pending_count() != 0) @(posedge clock);
   endtask

   // Fill every slot, poke at the full queue, sort it all, search, drain.
   task automatic fill_episode();
      drain_queue();
      while (board.used_slots() < slq_pkg::DEPTH)
         send(slq_pkg::FN_ENQ, pick_value($urandom_range(2)));
      repeat (2) send(slq_pkg::FN_ENQ, word_type'($urandom));
      repeat (3) send(slq_pkg::FN_DEQ, word_type'($urandom));
      // freed slots at the front stay unusable: no wrap
      send(slq_pkg::FN_ENQ, word_type'($urandom));
      send(slq_pkg::FN_SEARCH, board.live_entry(0));
      send(slq_pkg::FN_SORT, word_type'($urandom));
      repeat (6) send(slq_pkg::FN_SEARCH, pick_key(2));
      send(slq_pkg::FN_SEARCH, board.live_entry(board.live_count() - 1));
      drain_queue();
      send(slq_pkg::FN_DEQ, word_type'($urandom));
   endtask

   task automatic run_episode();
      int unsigned fill;
      int unsigned style;
      int unsigned n_deq;
      fill  = $urandom_range(1, 12);
      style = $urandom_range(2);
      repeat (fill) begin
         if ($urandom_range(9) == 0)
            send(slq_pkg::func_type'($urandom_range(3)), word_type'($urandom));
         send(slq_pkg::FN_ENQ, pick_value(style));
      end
      if ($urandom_range(9) < 7) send(slq_pkg::FN_SORT, word_type'($urandom));
      repeat ($urandom_range(1, 5)) send(slq_pkg::FN_SEARCH, pick_key(style));
      // keep the live set small so that sorts stay short
      if (board.live_count() > 20 || $urandom_range(1) == 1)
         n_deq = board.live_count() + $urandom_range(1);
      else
         n_deq = $urandom_range(board.live_count());
      repeat (n_deq) send(slq_pkg::FN_DEQ, word_type'($urandom));
   endtask

   initial begin
      int unsigned phase_goal;
      board                 = new();
      items_sent            = 0;
      hold_off_cycles       = 0;
      snd_idle_pct          = 0;
      rcv_idle_pct          = 0;
      clock                 = 1'b0;
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.func          = slq_pkg::FN_ENQ;
      req_bus.operand_value = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed corners
      send(slq_pkg::FN_DEQ, '0);
      send(slq_pkg::FN_SEARCH, '0);
      send(slq_pkg::FN_SORT, '0);
      send(slq_pkg::FN_ENQ, WORD_MAX);
      send(slq_pkg::FN_SORT, '0);
      send(slq_pkg::FN_SEARCH, WORD_MAX);
      send(slq_pkg::FN_ENQ, WORD_MIN);
      send(slq_pkg::FN_SEARCH, WORD_MIN);
      send(slq_pkg::FN_SORT, '1);
      send(slq_pkg::FN_SEARCH, WORD_MIN);
      send(slq_pkg::FN_SEARCH, WORD_MAX);
      send(slq_pkg::FN_ENQ, '0);
      send(slq_pkg::FN_ENQ, -1);
      send(slq_pkg::FN_ENQ, 5);
      send(slq_pkg::FN_ENQ, 5);
      send(slq_pkg::FN_SEARCH, 5);
      send(slq_pkg::FN_SORT, '0);
      send(slq_pkg::FN_SEARCH, 5);
      repeat (3) send(slq_pkg::FN_DEQ, '0);
      send(slq_pkg::FN_SEARCH, 5);
      repeat (3) send(slq_pkg::FN_DEQ, '1);
      send(slq_pkg::FN_DEQ, '0);

      for (int phase = 0; phase < 3; phase++) begin
         wait_for_idle();
         case (phase)
            0: begin
               snd_idle_pct = 23;
               rcv_idle_pct = 51;
            end
            1: begin
               snd_idle_pct = 51;
               rcv_idle_pct = 23;
            end
            default: begin
               snd_idle_pct = 0;
               rcv_idle_pct = 0;
               // stall the output while requests keep coming
               hold_off_cycles = 400;
            end
         endcase
         phase_goal = items_sent + 440;
         if (phase != 1) fill_episode();
         while (items_sent < phase_goal) run_episode();
      end

      wait_for_idle();
      repeat (20) @(posedge clock);
      if (board.failures == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule

>>> files.f
+incdir+sv
sv/slq_pkg.sv
sv/slq_ifs.sv
sv/slq_ctrl.sv
sv/slq_dp.sv
sv/sortable_linear_queue_top.sv
dv/tb_sortable_linear_queue_top.sv
